/* rtl/core/div64_pkg.sv */
// Package for the 64-bit restoring divider.
// Holds command/result word types, sequencer states and control structs.
// No dependencies.
`default_nettype none

package div64_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 6;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div64_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
        logic              divide_by_zero;
    } div64_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ITER,
        ST_FIX
    } div64_state_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic step;
        logic fix;
    } div64_ctrl_t;

    typedef struct packed {
        logic den_zero;
    } div64_stat_t;

endpackage

`default_nettype wire

/* rtl/core/div64_ctrl.sv */
// Sequencer for the 64-bit restoring divider.
// Steps the shared subtract unit through setup, 64 iterations (none for a zero divisor) and fix-up.
// Depends on div64_pkg.
`default_nettype none

module div64_ctrl
    import div64_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire div64_stat_t stat,
    output div64_ctrl_t      ctrl,
    output logic             busy,
    output logic             done
);

    div64_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                ctrl.setup = 1'b1;
                cnt_next   = LAST_STEP;
                state_next = stat.den_zero ? ST_FIX : ST_ITER;
            end
            ST_ITER:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                ctrl.fix   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/div64_core.sv */
// Datapath for the 64-bit restoring divider: operand and partial remainder
// registers around one 65-bit subtractor, plus magnitude and sign fix-up.
// Depends on div64_pkg.
`default_nettype none

module div64_core
    import div64_pkg::*;
(
    input  wire logic        clk,
    input  wire div64_ctrl_t ctrl,
    input  wire div64_in_t   cmd,
    output div64_stat_t      stat,
    output div64_out_t       result
);

    logic              action_reg;
    logic [DATA_W-1:0] orig_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W-1:0] rem_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic              dbz_reg;
    div64_out_t        result_reg;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   partial;
    logic [DATA_W:0]   diff;
    logic              take;
    logic [DATA_W-1:0] quo_fix;
    logic [DATA_W-1:0] rem_fix;

    assign num_mag = (action_reg && quo_reg[DATA_W-1]) ? (DATA_W'(0) - quo_reg) : quo_reg;
    assign den_mag = (action_reg && den_reg[DATA_W-1]) ? (DATA_W'(0) - den_reg) : den_reg;

    assign partial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = partial - {1'b0, den_reg};
    assign take    = !diff[DATA_W];

    assign quo_fix = neg_q_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
    assign rem_fix = neg_r_reg ? (DATA_W'(0) - rem_reg) : rem_reg;

    assign stat.den_zero = (den_reg == '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            action_reg <= cmd.action;
            orig_reg   <= cmd.dividend;
            quo_reg    <= cmd.dividend;
            den_reg    <= cmd.divisor;
        end
        if (ctrl.setup)
        begin
            quo_reg   <= num_mag;
            den_reg   <= den_mag;
            rem_reg   <= '0;
            neg_q_reg <= action_reg && (quo_reg[DATA_W-1] ^ den_reg[DATA_W-1]);
            neg_r_reg <= action_reg && quo_reg[DATA_W-1];
            dbz_reg   <= (den_reg == '0);
        end
        if (ctrl.step)
        begin
            rem_reg <= take ? diff[DATA_W-1:0] : partial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], take};
        end
        if (ctrl.fix)
        begin
            if (dbz_reg)
            begin
                result_reg.quotient  <= '1;
                result_reg.remainder <= orig_reg;
            end
            else
            begin
                result_reg.quotient  <= quo_fix;
                result_reg.remainder <= rem_fix;
            end
            result_reg.divide_by_zero <= dbz_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/divider_64bit_signed_unsigned.sv */
// Top level of the 64-bit signed/unsigned restoring divider.
// Instantiates div64_ctrl and div64_core; depends on div64_pkg.
//
// Usage:
//   Command word on cmd (action, dividend, divisor) is taken at a rising edge
//   with start high and busy low. action = 0 divides unsigned, 1 signed.
//   The result word (quotient, remainder, divide_by_zero) is valid on result
//   when done is high for exactly one cycle; the receiver cannot stall it.
// Sequencing:
//   One quotient bit per cycle from a single shared 65-bit subtractor:
//   setup (magnitudes), 64 iterations, then sign fix-up; busy is high
//   through all of these and done follows in the next cycle.
//   A zero divisor skips the iterations and goes from setup to fix-up.
//   A new command may be issued in the cycle done is high; none is taken
//   while busy is high, so only one word is in flight at a time.
// Zero divisor: divide_by_zero = 1, quotient all ones, remainder = dividend.
// Reset: rst_n (async, active low) returns the sequencer to idle and clears
//   done; any word in flight is dropped.
`default_nettype none

module divider_64bit_signed_unsigned
    import div64_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire div64_in_t cmd,
    output logic           busy,
    output logic           done,
    output div64_out_t     result
);

    div64_ctrl_t ctrl;
    div64_stat_t stat;

    div64_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    div64_core u_core (
        .clk    (clk),
        .ctrl   (ctrl),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_dbz_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |-> (result.quotient == '1))
        else $error("divide by zero quotient not all ones");

endmodule

`default_nettype wire

/* verif/tb_divider_64bit_signed_unsigned.sv */
// Self-checking testbench for the 64-bit signed/unsigned restoring divider.
// Drives command words, predicts quotient/remainder/divide-by-zero per word and
// checks each result word in order; depends on div64_pkg and the divider RTL.
`default_nettype none

module tb_divider_64bit_signed_unsigned;
    timeunit 1ns;
    timeprecision 1ps;

    import div64_pkg::*;

    localparam logic ACT_UNSIGNED = 1'b0;
    localparam logic ACT_SIGNED   = 1'b1;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    localparam int NUM_RANDOM = 1080;
    localparam int TAIL_CYCLES = 70;

    class div_scoreboard;
        div64_out_t expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function logic [DATA_W-1:0] magnitude_of(logic [DATA_W-1:0] v);
            return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
        endfunction

        function div64_out_t divide_word(div64_in_t c);
            div64_out_t r;
            logic [DATA_W-1:0] num_mag;
            logic [DATA_W-1:0] den_mag;
            logic num_neg;
            logic den_neg;
            r.divide_by_zero = 1'b0;
            if (c.divisor == '0) begin
                r.quotient = ALL_ONES;
                r.remainder = c.dividend;
                r.divide_by_zero = 1'b1;
            end
            else if (c.action == ACT_SIGNED) begin
                num_neg = c.dividend[DATA_W-1];
                den_neg = c.divisor[DATA_W-1];
                num_mag = magnitude_of(c.dividend);
                den_mag = magnitude_of(c.divisor);
                r.quotient = num_mag / den_mag;
                r.remainder = num_mag % den_mag;
                if (num_neg != den_neg)
                    r.quotient = DATA_W'(0) - r.quotient;
                if (num_neg)
                    r.remainder = DATA_W'(0) - r.remainder;
            end
            else begin
                r.quotient = c.dividend / c.divisor;
                r.remainder = c.dividend % c.divisor;
            end
            return r;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_word(div64_in_t c);
            expected_q.push_back(divide_word(c));
        endfunction

        task check_word(div64_out_t got);
            div64_out_t exp_word;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result word q=%h r=%h dbz=%b",
                                 got.quotient, got.remainder, got.divide_by_zero));
            end
            else begin
                exp_word = expected_q.pop_front();
                if (got.quotient !== exp_word.quotient)
                    report($sformatf("quotient got %h exp %h",
                                     got.quotient, exp_word.quotient));
                if (got.remainder !== exp_word.remainder)
                    report($sformatf("remainder got %h exp %h",
                                     got.remainder, exp_word.remainder));
                if (got.divide_by_zero !== exp_word.divide_by_zero)
                    report($sformatf("divide_by_zero got %b exp %b",
                                     got.divide_by_zero, exp_word.divide_by_zero));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    div64_in_t  cmd;
    logic       busy;
    logic       done;
    div64_out_t result;

    div_scoreboard sb;
    bit no_gap_run;

    divider_64bit_signed_unsigned u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(result);
    end

    function logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function logic [DATA_W-1:0] corner_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 64'd1;
            2: v = ALL_ONES;
            3: v = MOST_NEG;
            4: v = MOST_POS;
            5: v = MOST_NEG + 64'd1;
            6: v = 64'd2;
            default: v = ALL_ONES - 64'd1;
        endcase
        return v;
    endfunction

    function div64_in_t make_word(logic act, logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
        div64_in_t c;
        c.action = act;
        c.dividend = num;
        c.divisor = den;
        return c;
    endfunction

    function div64_in_t random_word();
        div64_in_t c;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        num = rand64();
        den = rand64();
        case ($urandom_range(0, 9))
            0: den = '0;
            1: den = DATA_W'($urandom_range(1, 15));
            2: den = den >> $urandom_range(0, 63);
            3: num = num >> $urandom_range(0, 63);
            4: begin
                num = corner_value();
                den = corner_value();
            end
            5: begin
                num = num >> $urandom_range(0, 63);
                den = den >> $urandom_range(0, 63);
            end
            6: den = $urandom_range(0, 1) ? num : num + DATA_W'($urandom_range(0, 3));
            7: den = DATA_W'(0) - (den >> $urandom_range(1, 63));
            default: ;
        endcase
        c = make_word($urandom_range(0, 1) ? ACT_SIGNED : ACT_UNSIGNED, num, den);
        return c;
    endfunction

    task issue_word(div64_in_t c, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        sb.note_word(c);
    endtask

    task drain_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function int unsigned draw_gap();
        return no_gap_run ? 0 : $urandom_range(0, 7);
    endfunction

    initial
    begin
        div64_in_t dir_q[$];
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        no_gap_run = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_q.push_back(make_word(ACT_UNSIGNED, 64'd0, 64'd1));
        dir_q.push_back(make_word(ACT_UNSIGNED, ALL_ONES, 64'd1));
        dir_q.push_back(make_word(ACT_UNSIGNED, ALL_ONES, ALL_ONES));
        dir_q.push_back(make_word(ACT_UNSIGNED, ALL_ONES, 64'd0));
        dir_q.push_back(make_word(ACT_SIGNED, MOST_NEG, 64'd0));
        dir_q.push_back(make_word(ACT_SIGNED, 64'd0, 64'd0));
        dir_q.push_back(make_word(ACT_SIGNED, MOST_NEG, ALL_ONES));
        dir_q.push_back(make_word(ACT_UNSIGNED, MOST_NEG, ALL_ONES));
        dir_q.push_back(make_word(ACT_SIGNED, MOST_NEG, 64'd1));
        dir_q.push_back(make_word(ACT_SIGNED, MOST_NEG, MOST_NEG));
        dir_q.push_back(make_word(ACT_SIGNED, MOST_POS, MOST_NEG));
        dir_q.push_back(make_word(ACT_SIGNED, MOST_POS, ALL_ONES));
        dir_q.push_back(make_word(ACT_SIGNED, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE));
        dir_q.push_back(make_word(ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2));
        dir_q.push_back(make_word(ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9,
                                  64'hFFFF_FFFF_FFFF_FFFE));
        dir_q.push_back(make_word(ACT_UNSIGNED, 64'd5, 64'd1234_5678));
        dir_q.push_back(make_word(ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFFB, 64'd1234_5678));
        dir_q.push_back(make_word(ACT_SIGNED, 64'd0, ALL_ONES));
        dir_q.push_back(make_word(ACT_SIGNED, 64'd1, ALL_ONES));
        dir_q.push_back(make_word(ACT_UNSIGNED, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_0001_0001));
        dir_q.push_back(make_word(ACT_SIGNED, 64'hFEDC_BA98_7654_3210, 64'h0000_0000_0001_0001));
        foreach (dir_q[i])
            issue_word(dir_q[i], $urandom_range(0, 7));

        drain_results();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 50 == 0)
                no_gap_run = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 149) == 0)
                drain_results();
            issue_word(random_word(), draw_gap());
        end
        start <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected result words never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/div64_pkg.sv
rtl/core/div64_ctrl.sv
rtl/core/div64_core.sv
rtl/core/divider_64bit_signed_unsigned.sv
verif/tb_divider_64bit_signed_unsigned.sv
